// ===== hdl/moldudp64_packet_builder_defines.svh =====
// Assertion macros used by the checker file of the packet builder.
`ifndef MOLDUDP64_PACKET_BUILDER_DEFINES_SVH
`define MOLDUDP64_PACKET_BUILDER_DEFINES_SVH

// Same-cycle implication, reset masks the check.
`define MDP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masks the check.
`define MDP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mdp_pkg.sv =====
// Shared types and constants of the MoldUDP64 packet builder.
package mdp_pkg;

    // Packet geometry
    localparam int MAX_PACKET_BYTES = 2048;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int OFF_W            = 11;
    localparam int LEN_W            = 16;
    localparam int LENP_W           = LEN_W + 1;
    localparam int SEQ_W            = 64;
    localparam int CNT_W            = 16;
    localparam int LIM_W            = 12;
    localparam int HEADER_BYTES     = 20;
    localparam int LIMIT_MIN        = 24;
    localparam int DEFAULT_PAYLOAD  = 1400;
    localparam logic [CNT_W-1:0] EOS_COUNT = 16'hFFFF;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 1'd1;

    // Input action codes
    localparam logic [2:0] ACT_START = 3'd0;
    localparam logic [2:0] ACT_BYTE  = 3'd1;
    localparam logic [2:0] ACT_CLOSE = 3'd2;
    localparam logic [2:0] ACT_HBEAT = 3'd3;
    localparam logic [2:0] ACT_EOS   = 3'd4;

    // Command queue depth
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_START,
        OP_BYTE,
        OP_CLOSE,
        OP_HBEAT,
        OP_EOS
    } t_op;

    typedef enum logic [2:0] {
        K_BODY  = 3'd0,
        K_DATA  = 3'd1,
        K_HBEAT = 3'd2,
        K_EOS   = 3'd3,
        K_DROP  = 3'd4
    } t_kind;

    typedef struct packed {
        t_op               op;
        logic [LEN_W-1:0]  len;
        logic [LENP_W-1:0] len_p2;
        logic [7:0]        data;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_push;

endpackage

// ===== hdl/mdp_in_if.sv =====
// Input item channel: action, message length and data byte.
interface mdp_in_if;
    import mdp_pkg::*;

    logic             valid;
    logic             ready;
    logic [2:0]       action;
    logic [LEN_W-1:0] msg_length;
    logic [7:0]       data_byte;

    modport source (output valid, action, msg_length, data_byte, input ready);
    modport sink   (input valid, action, msg_length, data_byte, output ready);
endinterface

// ===== hdl/mdp_out_if.sv =====
// Result item channel: body bytes, headers and drop notices.
interface mdp_out_if;
    import mdp_pkg::*;

    logic             valid;
    logic             ready;
    logic [2:0]       kind;
    logic [7:0]       byte_value;
    logic [OFF_W-1:0] byte_offset;
    logic [SEQ_W-1:0] sequence_number;
    logic [CNT_W-1:0] message_count;
    logic [LIM_W-1:0] packet_length;
    logic             last;

    modport source (output valid, kind, byte_value, byte_offset, sequence_number,
                    message_count, packet_length, last, input ready);
    modport sink   (input valid, kind, byte_value, byte_offset, sequence_number,
                    message_count, packet_length, last, output ready);
endinterface

// ===== hdl/mdp_front.sv =====
// Front end: accept input items, classify them and push commands.
module mdp_front (
    mdp_in_if.sink          i_in,
    input  logic            i_q_full,
    output mdp_pkg::t_q_push o_push
);
    import mdp_pkg::*;

    logic known;
    t_op  op;

    // Decode the action; unknown codes are accepted and dropped
    always_comb begin
        known = 1'b1;
        op    = OP_START;
        unique case (i_in.action)
            ACT_START: op = OP_START;
            ACT_BYTE:  op = OP_BYTE;
            ACT_CLOSE: op = OP_CLOSE;
            ACT_HBEAT: op = OP_HBEAT;
            ACT_EOS:   op = OP_EOS;
            default:   known = 1'b0;
        endcase
    end

    assign i_in.ready = !i_q_full;

    // Build the command, precompute the reserved size
    always_comb begin
        o_push.valid      = i_in.valid && !i_q_full && known;
        o_push.cmd.op     = op;
        o_push.cmd.len    = i_in.msg_length;
        o_push.cmd.len_p2 = {1'b0, i_in.msg_length} + LENP_W'(2);
        o_push.cmd.data   = i_in.data_byte;
    end
endmodule

// ===== hdl/mdp_queue.sv =====
// Short command queue between the front end and the packet engine.
module mdp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mdp_pkg::t_q_push i_push,
    input  logic             i_pop,
    output logic             o_full,
    output mdp_pkg::t_q_head o_head
);
    import mdp_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0] r_count, n_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && (r_count != '0);

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + Q_AW'(1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + Q_AW'(1) : r_rd_ptr;
        n_count  = r_count + Q_CW'(do_push) - Q_CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store commands
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];
endmodule

// ===== hdl/mdp_back.sv =====
// Packet engine: session state, packet layout and the result register.
module mdp_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mdp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mdp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  mdp_pkg::t_q_head                 i_head,
    output logic                             o_pop,
    mdp_out_if.source                        o_out
);
    import mdp_pkg::*;

    // Session and packet state
    logic [SEQ_W-1:0] r_next_seq, n_next_seq;
    logic [POS_W-1:0] r_wp, n_wp;
    logic [CNT_W-1:0] r_msgs, n_msgs;
    logic [LEN_W-1:0] r_br, n_br;
    logic             r_drop, n_drop;
    logic [LIM_W-1:0] r_lim, n_lim;
    logic [LIM_W-1:0] r_lim_body, n_lim_body;
    // Pending second length byte of a start
    logic             r_b1_pend, n_b1_pend;
    logic [7:0]       r_b1_val, n_b1_val;
    logic [OFF_W-1:0] r_b1_off, n_b1_off;
    // Result register
    logic             r_out_valid, n_out_valid;
    t_kind            r_kind, n_kind;
    logic [7:0]       r_bval, n_bval;
    logic [OFF_W-1:0] r_boff, n_boff;
    logic [SEQ_W-1:0] r_seq, n_seq;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [LIM_W-1:0] r_plen, n_plen;
    logic             r_last, n_last;

    logic              go;
    logic              emit;
    logic              need_close;
    logic              oversize;
    logic [POS_W-1:0]  base;
    logic [LIM_W-1:0]  clamp;
    logic [POS_W-1:0]  body_pos;

    assign go = i_head.valid && (!r_out_valid || o_out.ready);

    assign need_close = (LENP_W'(r_wp) + i_head.cmd.len_p2) > LENP_W'(r_lim);
    assign oversize   = i_head.cmd.len_p2 > LENP_W'(r_lim_body);
    assign base       = need_close ? POS_W'(HEADER_BYTES) : r_wp;
    assign body_pos   = r_wp - r_br[POS_W-1:0];

    // Clamp the payload limit on a write
    always_comb begin
        clamp = i_cfg_data[LIM_W-1:0];
        if (clamp < LIM_W'(LIMIT_MIN)) begin
            clamp = LIM_W'(LIMIT_MIN);
        end else if (clamp > LIM_W'(MAX_PACKET_BYTES)) begin
            clamp = LIM_W'(MAX_PACKET_BYTES);
        end
    end

    // Execute one step of the head command, at most one result per cycle
    always_comb begin
        n_next_seq  = r_next_seq;
        n_wp        = r_wp;
        n_msgs      = r_msgs;
        n_br        = r_br;
        n_drop      = r_drop;
        n_lim       = r_lim;
        n_lim_body  = r_lim_body;
        n_b1_pend   = r_b1_pend;
        n_b1_val    = r_b1_val;
        n_b1_off    = r_b1_off;
        n_out_valid = r_out_valid && !o_out.ready;
        emit        = 1'b0;
        n_kind      = K_BODY;
        n_bval      = '0;
        n_boff      = '0;
        n_seq       = '0;
        n_cnt       = '0;
        n_plen      = '0;
        n_last      = 1'b0;
        o_pop       = 1'b0;

        if (go) begin
            if (r_b1_pend) begin
                // Finish a start with its low length byte
                emit      = 1'b1;
                n_bval    = r_b1_val;
                n_boff    = r_b1_off;
                n_last    = 1'b1;
                n_b1_pend = 1'b0;
                o_pop     = 1'b1;
            end else begin
                unique case (i_head.cmd.op)
                    OP_START: begin
                        n_br   = '0;
                        n_drop = 1'b0;
                        if (oversize) begin
                            emit   = 1'b1;
                            n_kind = K_DROP;
                            n_last = 1'b1;
                            n_drop = (i_head.cmd.len != '0);
                            n_br   = i_head.cmd.len;
                            o_pop  = 1'b1;
                        end else if (need_close && (r_msgs != '0)) begin
                            // Close the full packet, retry the start next step
                            emit       = 1'b1;
                            n_kind     = K_DATA;
                            n_seq      = r_next_seq;
                            n_cnt      = r_msgs;
                            n_plen     = LIM_W'(r_wp);
                            n_next_seq = r_next_seq + SEQ_W'(r_msgs);
                            n_wp       = POS_W'(HEADER_BYTES);
                            n_msgs     = '0;
                        end else begin
                            emit      = 1'b1;
                            n_bval    = i_head.cmd.len[15:8];
                            n_boff    = base[OFF_W-1:0];
                            n_b1_pend = 1'b1;
                            n_b1_val  = i_head.cmd.len[7:0];
                            n_b1_off  = base[OFF_W-1:0] + OFF_W'(1);
                            n_wp      = base + i_head.cmd.len_p2[POS_W-1:0];
                            n_msgs    = r_msgs + CNT_W'(1);
                            n_br      = i_head.cmd.len;
                        end
                    end
                    OP_BYTE: begin
                        if (r_br != '0) begin
                            if (!r_drop) begin
                                emit   = 1'b1;
                                n_bval = i_head.cmd.data;
                                n_boff = body_pos[OFF_W-1:0];
                                n_last = 1'b1;
                            end
                            n_br = r_br - LEN_W'(1);
                            if (r_br == LEN_W'(1)) begin
                                n_drop = 1'b0;
                            end
                        end
                        o_pop = 1'b1;
                    end
                    OP_CLOSE: begin
                        n_br   = '0;
                        n_drop = 1'b0;
                        if (r_msgs != '0) begin
                            emit       = 1'b1;
                            n_kind     = K_DATA;
                            n_seq      = r_next_seq;
                            n_cnt      = r_msgs;
                            n_plen     = LIM_W'(r_wp);
                            n_last     = 1'b1;
                            n_next_seq = r_next_seq + SEQ_W'(r_msgs);
                        end
                        n_wp   = POS_W'(HEADER_BYTES);
                        n_msgs = '0;
                        o_pop  = 1'b1;
                    end
                    OP_HBEAT, OP_EOS: begin
                        n_br   = '0;
                        n_drop = 1'b0;
                        emit   = 1'b1;
                        n_wp   = POS_W'(HEADER_BYTES);
                        if (r_msgs != '0) begin
                            // Close the open packet first
                            n_kind     = K_DATA;
                            n_seq      = r_next_seq;
                            n_cnt      = r_msgs;
                            n_plen     = LIM_W'(r_wp);
                            n_next_seq = r_next_seq + SEQ_W'(r_msgs);
                            n_msgs     = '0;
                        end else begin
                            n_kind = (i_head.cmd.op == OP_EOS) ? K_EOS : K_HBEAT;
                            n_seq  = r_next_seq;
                            n_cnt  = (i_head.cmd.op == OP_EOS) ? EOS_COUNT : '0;
                            n_plen = LIM_W'(HEADER_BYTES);
                            n_last = 1'b1;
                            o_pop  = 1'b1;
                        end
                    end
                    default: begin
                        o_pop = 1'b1;
                    end
                endcase
            end
        end

        if (emit) begin
            n_out_valid = 1'b1;
        end

        // Apply configuration writes
        if (i_cfg_we) begin
            if (i_cfg_idx == CFG_START_SEQ) begin
                n_next_seq = i_cfg_data;
            end else if (i_cfg_idx == CFG_MAX_PAYLOAD) begin
                n_lim      = clamp;
                n_lim_body = clamp - LIM_W'(HEADER_BYTES);
            end
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_seq  <= SEQ_W'(1);
            r_wp        <= POS_W'(HEADER_BYTES);
            r_msgs      <= '0;
            r_br        <= '0;
            r_drop      <= 1'b0;
            r_lim       <= LIM_W'(DEFAULT_PAYLOAD);
            r_lim_body  <= LIM_W'(DEFAULT_PAYLOAD - HEADER_BYTES);
            r_b1_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_next_seq  <= n_next_seq;
            r_wp        <= n_wp;
            r_msgs      <= n_msgs;
            r_br        <= n_br;
            r_drop      <= n_drop;
            r_lim       <= n_lim;
            r_lim_body  <= n_lim_body;
            r_b1_pend   <= n_b1_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Load result payload and the pending length byte
    always_ff @(posedge i_clk) begin
        r_b1_val <= n_b1_val;
        r_b1_off <= n_b1_off;
        if (emit) begin
            r_kind <= n_kind;
            r_bval <= n_bval;
            r_boff <= n_boff;
            r_seq  <= n_seq;
            r_cnt  <= n_cnt;
            r_plen <= n_plen;
            r_last <= n_last;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.kind            = r_kind;
    assign o_out.byte_value      = r_bval;
    assign o_out.byte_offset     = r_boff;
    assign o_out.sequence_number = r_seq;
    assign o_out.message_count   = r_cnt;
    assign o_out.packet_length   = r_plen;
    assign o_out.last            = r_last;
endmodule

// ===== hdl/moldudp64_packet_builder.sv =====
// Top level of the MoldUDP64 packet builder.
// Packs length-prefixed messages into MoldUDP64 packets and emits body bytes with
// their packet offsets plus a header descriptor per closed packet. Input items go
// through a decoder into a four-entry command queue; the packet engine behind it
// produces one result per cycle, unless the output stalls, into a single output
// register, so the input side keeps accepting while a result waits until the
// queue fills. A start emits its high and then its low length byte, after a data
// header when it first closes the full packet; a heartbeat or end of session
// emits its header after the data header of any open packet. Unknown actions are
// accepted and discarded in the decoder. An item passes the command queue, then
// the output register, before its first result shows. The payload limit is
// clamped to 24..2048 when written; a start sequence write reloads the next
// sequence number. Configuration must be written while idle; not block-enforced.
module moldudp64_packet_builder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mdp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mdp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    mdp_in_if.sink                          i_in,
    mdp_out_if.source                       o_out
);
    import mdp_pkg::*;

    t_q_push push;
    t_q_head head;
    logic    q_full;
    logic    pop;

    // Decode and accept items
    mdp_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push)
    );

    // Buffer commands
    mdp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    // Build packets and deliver results
    mdp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_head     (head),
        .o_pop      (pop),
        .o_out      (o_out)
    );
endmodule

// ===== hdl/mdp_checker.sv =====
// Port-level assertions for the packet builder and their bind.
`include "moldudp64_packet_builder_defines.svh"

module mdp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [2:0]                    i_kind,
    input logic [7:0]                    i_byte_value,
    input logic [mdp_pkg::OFF_W-1:0]     i_byte_offset,
    input logic [mdp_pkg::SEQ_W-1:0]     i_seq,
    input logic [mdp_pkg::CNT_W-1:0]     i_count,
    input logic [mdp_pkg::LIM_W-1:0]     i_plen,
    input logic                          i_last
);
    import mdp_pkg::*;

    // Hold a stalled result
    `MDP_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_kind) && $stable(i_byte_value) && $stable(i_byte_offset) && $stable(i_seq) && $stable(i_count) && $stable(i_plen) && $stable(i_last), "stalled result changed")

    // Heartbeat and end headers are bare 20-byte headers ending their item
    `MDP_ASSERT_IMP(a_hb_hdr, i_out_valid && (i_kind == K_HBEAT || i_kind == K_EOS), i_plen == LIM_W'(HEADER_BYTES) && i_last && (i_kind == K_EOS ? i_count == EOS_COUNT : i_count == '0), "bad heartbeat or end header")

    // Data headers describe a packet holding at least one message
    `MDP_ASSERT_IMP(a_data_hdr, i_out_valid && i_kind == K_DATA, i_count != '0 && i_plen >= LIM_W'(HEADER_BYTES + 2) && i_plen <= LIM_W'(MAX_PACKET_BYTES), "bad data header")

    // Body bytes sit past the header and a drop ends its item
    `MDP_ASSERT_IMP(a_body_drop, i_out_valid && (i_kind == K_BODY || i_kind == K_DROP), i_seq == '0 && i_count == '0 && i_plen == '0 && (i_kind == K_DROP ? i_last : i_byte_offset >= OFF_W'(HEADER_BYTES)), "bad body or drop result")
endmodule

bind moldudp64_packet_builder mdp_checker u_mdp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_kind        (o_out.kind),
    .i_byte_value  (o_out.byte_value),
    .i_byte_offset (o_out.byte_offset),
    .i_seq         (o_out.sequence_number),
    .i_count       (o_out.message_count),
    .i_plen        (o_out.packet_length),
    .i_last        (o_out.last)
);

// ===== verif/tb.sv =====
// Testbench for the MoldUDP64 packet builder: directed and random items checked against a predictor.
`timescale 1ns / 1ps

module tb;
    import mdp_pkg::*;

    // Action codes the block does not define, sent to check that they are ignored
    localparam logic [2:0] ACT_SPARE_A = 3'd5;
    localparam logic [2:0] ACT_SPARE_B = 3'd6;
    localparam logic [2:0] ACT_SPARE_C = 3'd7;

    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct {
        t_kind            kind;
        logic [7:0]       value;
        logic [OFF_W-1:0] offset;
        logic [SEQ_W-1:0] seq;
        logic [CNT_W-1:0] count;
        logic [LIM_W-1:0] plen;
        logic             last;
    } t_pkt_result;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    mdp_in_if  in_ch();
    mdp_out_if out_ch();

    moldudp64_packet_builder DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Predicted packet state
    logic [SEQ_W-1:0] next_seq;
    int unsigned      wpos;
    logic [CNT_W-1:0] pkt_msgs;
    int unsigned      remaining;
    bit               dropping;
    int unsigned      lim;

    t_pkt_result pkt_events[$];
    int          errors;
    int          sent_items;
    bit          bursty;
    int          stall_left;
    int          idle_cycles;

    always #2 clk = ~clk;

    // Predictor ---------------------------------------------------------------

    function automatic void add_result(t_kind k, logic [7:0] v, int unsigned off,
                                       logic [SEQ_W-1:0] s, logic [CNT_W-1:0] c,
                                       int unsigned pl);
        t_pkt_result r;
        r.kind   = k;
        r.value  = v;
        r.offset = OFF_W'(off);
        r.seq    = s;
        r.count  = c;
        r.plen   = LIM_W'(pl);
        r.last   = 1'b0;
        pkt_events.push_back(r);
    endfunction

    // Emit the data header of the open packet, if it holds anything, and restart it
    function automatic void close_pkt();
        if (pkt_msgs != 0) begin
            add_result(K_DATA, 8'd0, 0, next_seq, pkt_msgs, wpos);
            next_seq = next_seq + SEQ_W'(pkt_msgs);
        end
        wpos     = HEADER_BYTES;
        pkt_msgs = '0;
    endfunction

    function automatic int pack_item(logic [2:0] act, logic [LEN_W-1:0] len, logic [7:0] dat);
        int          n_prev;
        int unsigned mlen;
        n_prev = pkt_events.size();
        mlen   = len;
        case (act)
            ACT_START: begin
                remaining = 0;
                dropping  = 1'b0;
                if (2 + mlen > lim - HEADER_BYTES) begin
                    add_result(K_DROP, 8'd0, 0, '0, '0, 0);
                    dropping  = (mlen != 0);
                    remaining = mlen;
                end else begin
                    if (wpos + 2 + mlen > lim)
                        close_pkt();
                    add_result(K_BODY, len[15:8], wpos, '0, '0, 0);
                    add_result(K_BODY, len[7:0], wpos + 1, '0, '0, 0);
                    wpos      = wpos + 2 + mlen;
                    pkt_msgs  = pkt_msgs + 1'b1;
                    remaining = mlen;
                end
            end
            ACT_BYTE: begin
                if (remaining != 0) begin
                    if (!dropping)
                        add_result(K_BODY, dat, wpos - remaining, '0, '0, 0);
                    remaining--;
                    if (remaining == 0)
                        dropping = 1'b0;
                end
            end
            ACT_CLOSE: begin
                remaining = 0;
                dropping  = 1'b0;
                close_pkt();
            end
            ACT_HBEAT: begin
                remaining = 0;
                dropping  = 1'b0;
                close_pkt();
                add_result(K_HBEAT, 8'd0, 0, next_seq, '0, HEADER_BYTES);
            end
            ACT_EOS: begin
                remaining = 0;
                dropping  = 1'b0;
                close_pkt();
                add_result(K_EOS, 8'd0, 0, next_seq, EOS_COUNT, HEADER_BYTES);
            end
            default: ;
        endcase
        if (pkt_events.size() > n_prev)
            pkt_events[pkt_events.size() - 1].last = 1'b1;
        return pkt_events.size() - n_prev;
    endfunction

    // Shared tasks ------------------------------------------------------------

    // Drive one item, hold it until accepted, then predict its results
    task automatic send_item(input logic [2:0] act, input logic [LEN_W-1:0] len,
                             input logic [7:0] dat);
        if (bursty && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.action     <= act;
        in_ch.msg_length <= len;
        in_ch.data_byte  <= dat;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
        void'(pack_item(act, len, dat));
        sent_items++;
    endtask

    // Wait until every predicted result has arrived and the engine has gone quiet
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pkt_events.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both registers while idle; a start sequence write reloads the sequence
    task automatic apply_setting(input logic [SEQ_W-1:0] seq, input logic [LIM_W-1:0] payload);
        settle();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_START_SEQ;
        cfg_data <= seq;
        @(posedge clk);
        next_seq = seq;
        cfg_idx  <= CFG_MAX_PAYLOAD;
        cfg_data <= CFG_DATA_W'(payload);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (payload < LIMIT_MIN)
            lim = LIMIT_MIN;
        else if (payload > MAX_PACKET_BYTES)
            lim = MAX_PACKET_BYTES;
        else
            lim = payload;
    endtask

    // Tests -------------------------------------------------------------------

    // Default settings: empty messages, byte extremes, stray and unknown items,
    // abandoned messages, empty close, heartbeat and end with an open packet, oversize
    task automatic test_basic_items();
        send_item(ACT_START, 16'd0, 8'h00);
        send_item(ACT_START, 16'd3, 8'h00);
        send_item(ACT_BYTE, 16'd0, 8'h00);
        send_item(ACT_BYTE, 16'hFFFF, 8'hFF);
        send_item(ACT_BYTE, 16'd0, 8'hA5);
        send_item(ACT_BYTE, 16'd0, 8'h5A);
        send_item(ACT_SPARE_A, 16'd1, 8'h01);
        send_item(ACT_SPARE_B, 16'd2, 8'h02);
        send_item(ACT_SPARE_C, 16'd3, 8'h03);
        send_item(ACT_START, 16'd2, 8'h00);
        send_item(ACT_BYTE, 16'd0, 8'h11);
        send_item(ACT_START, 16'd1, 8'h00);
        send_item(ACT_CLOSE, 16'd0, 8'h00);
        send_item(ACT_CLOSE, 16'd0, 8'h00);
        send_item(ACT_START, 16'd4, 8'h00);
        send_item(ACT_BYTE, 16'd0, 8'h22);
        send_item(ACT_HBEAT, 16'd0, 8'h00);
        send_item(ACT_START, 16'hFFFF, 8'h00);
        send_item(ACT_BYTE, 16'd0, 8'h33);
        send_item(ACT_START, 16'd1378, 8'h00);
        send_item(ACT_BYTE, 16'd0, 8'h44);
        send_item(ACT_EOS, 16'd0, 8'h00);
        send_item(ACT_START, 16'd1379, 8'h00);
        send_item(ACT_CLOSE, 16'd0, 8'h00);
        send_item(ACT_HBEAT, 16'd0, 8'h00);
    endtask

    // Limit extremes, clamping on both sides, dropped bytes and sequence wrap
    task automatic test_limit_edges();
        apply_setting(64'd0, 12'd0);
        send_item(ACT_START, 16'd2, 8'h00);
        send_item(ACT_BYTE, 16'd0, 8'h80);
        send_item(ACT_BYTE, 16'd0, 8'h7F);
        send_item(ACT_START, 16'd0, 8'h00);
        send_item(ACT_START, 16'd3, 8'h00);
        repeat (3) send_item(ACT_BYTE, 16'd0, 8'hEE);
        send_item(ACT_BYTE, 16'd0, 8'hDD);
        send_item(ACT_EOS, 16'd0, 8'h00);

        apply_setting(64'hFFFF_FFFF_FFFF_FFFE, 12'hFFF);
        repeat (3) send_item(ACT_START, 16'd0, 8'h00);
        send_item(ACT_START, 16'd2026, 8'h00);
        send_item(ACT_BYTE, 16'd0, 8'h01);
        send_item(ACT_START, 16'd0, 8'h00);
        send_item(ACT_HBEAT, 16'd0, 8'h00);

        apply_setting(64'hFFFF_FFFF_FFFF_FFFF, 12'd24);
        send_item(ACT_START, 16'd3, 8'h00);
        send_item(ACT_START, 16'd2, 8'h00);
        send_item(ACT_CLOSE, 16'd0, 8'h00);

        apply_setting(64'h8000_0000_0000_0000, 12'd2048);
        send_item(ACT_START, 16'd2027, 8'h00);
        send_item(ACT_START, 16'd2026, 8'h00);
        send_item(ACT_EOS, 16'd0, 8'h00);
    endtask

    // Mostly well-formed messages with random content, plus noise and broken ones
    task automatic test_random_traffic(input int n_items);
        int          goal;
        int          r;
        int          pick;
        int unsigned fit;
        int unsigned mlen;
        int unsigned nbytes;
        goal = sent_items + n_items;
        while (sent_items < goal) begin
            r   = $urandom_range(0, 99);
            fit = lim - HEADER_BYTES - 2;
            if (r < 70) begin
                pick = $urandom_range(0, 9);
                if (pick < 8)
                    mlen = $urandom_range(0, fit < 12 ? fit : 12);
                else if (pick == 8)
                    mlen = $urandom_range(fit + 1, fit + 30);
                else
                    mlen = $urandom_range(0, 65535);
                send_item(ACT_START, LEN_W'(mlen), 8'($urandom));
                case ($urandom_range(0, 7))
                    0:       nbytes = $urandom_range(0, mlen);
                    1:       nbytes = mlen + 1;
                    default: nbytes = mlen;
                endcase
                if (nbytes > 40)
                    nbytes = $urandom_range(0, 40);
                repeat (nbytes) send_item(ACT_BYTE, LEN_W'($urandom), 8'($urandom));
            end else if (r < 80) begin
                send_item(ACT_CLOSE, LEN_W'($urandom), 8'($urandom));
            end else if (r < 85) begin
                send_item(ACT_HBEAT, LEN_W'($urandom), 8'($urandom));
            end else if (r < 88) begin
                send_item(ACT_EOS, LEN_W'($urandom), 8'($urandom));
            end else if (r < 94) begin
                send_item(ACT_BYTE, LEN_W'($urandom), 8'($urandom));
            end else begin
                case ($urandom_range(0, 2))
                    0:       send_item(ACT_SPARE_A, LEN_W'($urandom), 8'($urandom));
                    1:       send_item(ACT_SPARE_B, LEN_W'($urandom), 8'($urandom));
                    default: send_item(ACT_SPARE_C, LEN_W'($urandom), 8'($urandom));
                endcase
            end
        end
    endtask

    task automatic test_random_settings();
        apply_setting({$urandom, $urandom}, 12'($urandom_range(24, 64)));
        test_random_traffic(18);
        apply_setting(64'hFFFF_FFFF_FFFF_FFF0 + 64'($urandom_range(0, 15)),
                      12'($urandom_range(0, 23)));
        test_random_traffic(14);
        apply_setting({$urandom, $urandom}, 12'($urandom_range(2049, 4095)));
        test_random_traffic(18);
    endtask

    // Back-to-back traffic at full rate on both sides
    task automatic test_full_rate();
        apply_setting({$urandom, $urandom}, 12'($urandom_range(40, 120)));
        bursty = 1'b0;
        test_random_traffic(24);
    endtask

    // Result checking ---------------------------------------------------------

    function automatic void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            errors++;
        end
    endfunction

    // Compare each accepted result with the oldest prediction
    always @(posedge clk) begin : check_results
        t_pkt_result want;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pkt_events.size() == 0) begin
                $error("unexpected result: kind 0x%0h offset 0x%0h",
                       out_ch.kind, out_ch.byte_offset);
                errors++;
            end else begin
                want = pkt_events.pop_front();
                check_field("kind", 64'(want.kind), 64'(out_ch.kind));
                check_field("byte_value", 64'(want.value), 64'(out_ch.byte_value));
                check_field("byte_offset", 64'(want.offset), 64'(out_ch.byte_offset));
                check_field("sequence_number", want.seq, out_ch.sequence_number);
                check_field("message_count", 64'(want.count), 64'(out_ch.message_count));
                check_field("packet_length", 64'(want.plen), 64'(out_ch.packet_length));
                check_field("last", 64'(want.last), 64'(out_ch.last));
            end
        end
    end

    // Stall the result side in random bursts while bursty traffic is on
    always @(posedge clk) begin
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (bursty && $urandom_range(0, 3) == 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 4);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || cfg_we || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                || (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = CFG_START_SEQ;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.action     = ACT_START;
        in_ch.msg_length = '0;
        in_ch.data_byte  = '0;
        out_ch.ready     = 1'b0;
        stall_left       = 0;
        idle_cycles      = 0;
        errors           = 0;
        sent_items       = 0;
        bursty           = 1'b1;

        // Predictor state after reset
        next_seq  = 64'd1;
        wpos      = HEADER_BYTES;
        pkt_msgs  = '0;
        remaining = 0;
        dropping  = 1'b0;
        lim       = DEFAULT_PAYLOAD;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_items();
        test_limit_edges();
        test_random_settings();
        test_full_rate();
        settle();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
